FILE: design/epc_pkg.sv
package epc_pkg;

	// default sizes of the position loop
	localparam int POSITION_WIDTH_DEF     = 32;
	localparam int GAIN_FRACTION_BITS_DEF = 8;
	localparam int INTEGRAL_WIDTH_DEF     = 48;

	// fixed field widths
	localparam int GAIN_W  = 16;
	localparam int ERR_W   = 32;
	localparam int POS_W   = 32;
	localparam int LEVEL_W = 8;
	localparam int CFG_IDX_W = 2;

	// product terms clamp at +-2^TERM_LIMIT_EXP, sum of three fits SUM_W
	localparam int TERM_LIMIT_EXP = 50;
	localparam int SUM_W          = TERM_LIMIT_EXP + 4;

	localparam logic [LEVEL_W-1:0] DRIVE_MAX = 8'd255;

	// register reset values
	localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST  = 16'sd256;
	localparam logic signed [GAIN_W-1:0] INTEG_GAIN_RST = 16'sd0;
	localparam logic signed [GAIN_W-1:0] DERIV_GAIN_RST = 16'sd0;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 2'd2;

	// input item kinds
	localparam logic ACT_EDGE = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// results of one control tick
	typedef struct packed {
		logic signed [ERR_W-1:0] err;
		logic [LEVEL_W-1:0]      level;
		logic                    reverse;
	} epc_tick_t;

endpackage

FILE: design/epc_calc.sv
module epc_calc import epc_pkg::*; #(
	parameter int POSITION_WIDTH     = POSITION_WIDTH_DEF,
	parameter int GAIN_FRACTION_BITS = GAIN_FRACTION_BITS_DEF,
	parameter int INTEGRAL_WIDTH     = INTEGRAL_WIDTH_DEF
) (
	input  logic signed [POSITION_WIDTH-1:0] pos,
	input  logic signed [POS_W-1:0]          target,
	input  logic signed [ERR_W-1:0]          prev_err,
	input  logic signed [INTEGRAL_WIDTH-1:0] integ,
	input  logic signed [GAIN_W-1:0]         prop_gain,
	input  logic signed [GAIN_W-1:0]         integ_gain,
	input  logic signed [GAIN_W-1:0]         deriv_gain,
	output logic signed [INTEGRAL_WIDTH-1:0] integ_next,
	output epc_tick_t                        tick
);

	localparam int PI_W = GAIN_W + INTEGRAL_WIDTH;
	localparam int CW   = (PI_W > SUM_W) ? PI_W : SUM_W;
	localparam logic signed [CW-1:0] TERM_HI =
		{{(CW-TERM_LIMIT_EXP-1){1'b0}}, 1'b1, {TERM_LIMIT_EXP{1'b0}}};
	localparam logic signed [CW-1:0] TERM_LO = -TERM_HI;

	logic signed [POS_W:0]            pos_x, tgt_x, diff;
	logic signed [ERR_W-1:0]          err;
	logic signed [INTEGRAL_WIDTH:0]   integ_x, err_x, integ_sum;
	logic signed [ERR_W:0]            d;
	logic signed [GAIN_W+ERR_W-1:0]   p_prop;
	logic signed [GAIN_W+ERR_W:0]     p_deriv;
	logic signed [PI_W-1:0]           p_integ;
	logic signed [CW-1:0]             pi_x, pi_clamp;
	logic signed [SUM_W-1:0]          t_prop, t_deriv, t_integ, s;
	logic [SUM_W-1:0]                 mag, mag_sh;

	// error, saturated to 32 bits
	assign pos_x = (POS_W+1)'(pos);
	assign tgt_x = (POS_W+1)'(target);
	assign diff  = pos_x - tgt_x;
	always_comb begin
		if (diff[POS_W] != diff[POS_W-1])
			err = diff[POS_W] ? {1'b1, {(ERR_W-1){1'b0}}} : {1'b0, {(ERR_W-1){1'b1}}};
		else
			err = diff[ERR_W-1:0];
	end

	// saturating integral
	assign integ_x   = (INTEGRAL_WIDTH+1)'(integ);
	assign err_x     = (INTEGRAL_WIDTH+1)'(err);
	assign integ_sum = integ_x + err_x;
	always_comb begin
		if (integ_sum[INTEGRAL_WIDTH] != integ_sum[INTEGRAL_WIDTH-1])
			integ_next = integ_sum[INTEGRAL_WIDTH] ?
				{1'b1, {(INTEGRAL_WIDTH-1){1'b0}}} : {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
		else
			integ_next = integ_sum[INTEGRAL_WIDTH-1:0];
	end

	// derivative difference, exact
	assign d = $signed({err[ERR_W-1], err}) - $signed({prev_err[ERR_W-1], prev_err});

	// the three gain products
	assign p_prop  = (GAIN_W+ERR_W)'(prop_gain) * (GAIN_W+ERR_W)'(err);
	assign p_deriv = (GAIN_W+ERR_W+1)'(deriv_gain) * (GAIN_W+ERR_W+1)'(d);
	assign p_integ = PI_W'(integ_gain) * PI_W'(integ_next);

	// only the integral term can grow past the clamp
	assign pi_x = CW'(p_integ);
	always_comb begin
		if (pi_x > TERM_HI)
			pi_clamp = TERM_HI;
		else if (pi_x < TERM_LO)
			pi_clamp = TERM_LO;
		else
			pi_clamp = pi_x;
	end

	assign t_prop  = SUM_W'(p_prop);
	assign t_deriv = SUM_W'(p_deriv);
	assign t_integ = pi_clamp[SUM_W-1:0];
	assign s       = t_prop + t_deriv + t_integ;

	// magnitude, truncated toward zero and limited
	assign mag    = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
	assign mag_sh = mag >> GAIN_FRACTION_BITS;

	always_comb begin
		tick.err     = err;
		tick.reverse = s[SUM_W-1];
		if (|mag_sh[SUM_W-1:LEVEL_W])
			tick.level = DRIVE_MAX;
		else
			tick.level = mag_sh[LEVEL_W-1:0];
	end

endmodule

FILE: design/encoder_pid_position_control_top.sv
// a tick's result passes through the input register, then the result register, to the outputs;
// encoder edges give no result
// throughput: one item per cycle unless a tick is stalled, set by the single calc pass between the two registers
// a tick waits in the input register only while the result register is full and stalled
// reset (arst_n low, asynchronous) clears count, integral, previous error and
// both registers' valid flags, and loads the gains with 1.0, 0 and 0
module encoder_pid_position_control_top import epc_pkg::*; #(
	parameter int POSITION_WIDTH     = POSITION_WIDTH_DEF,
	parameter int GAIN_FRACTION_BITS = GAIN_FRACTION_BITS_DEF,
	parameter int INTEGRAL_WIDTH     = INTEGRAL_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [GAIN_W-1:0]         cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      action,
	input  logic                      channel_b_level,
	input  logic signed [POS_W-1:0]   target_position,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [LEVEL_W-1:0]        drive_level,
	output logic                      drive_reverse,
	output logic signed [POS_W-1:0]   position
);

	logic signed [GAIN_W-1:0]         prop_gain_q, integ_gain_q, deriv_gain_q;
	logic signed [POSITION_WIDTH-1:0] pos_q;
	logic signed [ERR_W-1:0]          prev_err_q;
	logic signed [INTEGRAL_WIDTH-1:0] integ_q, integ_next;
	logic                             valid_s1, action_s1, chan_b_s1;
	logic signed [POS_W-1:0]          target_s1;
	logic                             out_valid_q, drive_reverse_q;
	logic [LEVEL_W-1:0]               drive_level_q;
	logic signed [POS_W-1:0]          position_q, pos_ext;
	logic                             out_free, advance, in_take;
	epc_tick_t                        tick;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= PROP_GAIN_RST;
			integ_gain_q <= INTEG_GAIN_RST;
			deriv_gain_q <= DERIV_GAIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PROP_GAIN:  prop_gain_q  <= cfg_data;
				CFG_INTEG_GAIN: integ_gain_q <= cfg_data;
				CFG_DERIV_GAIN: deriv_gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake: an edge always leaves the input register, a tick needs room
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && (action_s1 == ACT_EDGE || out_free);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take || advance) begin
			valid_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			action_s1 <= action;
			chan_b_s1 <= channel_b_level;
			target_s1 <= target_position;
		end
	end

	epc_calc #(
		.POSITION_WIDTH    (POSITION_WIDTH),
		.GAIN_FRACTION_BITS(GAIN_FRACTION_BITS),
		.INTEGRAL_WIDTH    (INTEGRAL_WIDTH)
	) u_calc (
		.pos       (pos_q),
		.target    (target_s1),
		.prev_err  (prev_err_q),
		.integ     (integ_q),
		.prop_gain (prop_gain_q),
		.integ_gain(integ_gain_q),
		.deriv_gain(deriv_gain_q),
		.integ_next(integ_next),
		.tick      (tick)
	);

	assign pos_ext = POS_W'(pos_q);

	// loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			prev_err_q <= '0;
			integ_q    <= '0;
		end else if (advance) begin
			if (action_s1 == ACT_EDGE) begin
				pos_q <= chan_b_s1 ? pos_q + POSITION_WIDTH'(1) : pos_q - POSITION_WIDTH'(1);
			end else begin
				prev_err_q <= tick.err;
				integ_q    <= integ_next;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && action_s1 == ACT_TICK) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && action_s1 == ACT_TICK) begin
			drive_level_q   <= tick.level;
			drive_reverse_q <= tick.reverse;
			position_q      <= pos_ext;
		end
	end

	assign out_valid     = out_valid_q;
	assign drive_level   = drive_level_q;
	assign drive_reverse = drive_reverse_q;
	assign position      = position_q;

`ifndef SYNTHESIS
	// an edge moves the count by exactly one
	a_edge_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance && action_s1 == ACT_EDGE |=>
		(pos_q - $past(pos_q)) == POSITION_WIDTH'(1) ||
		($past(pos_q) - pos_q) == POSITION_WIDTH'(1))
		else $error("encoder edge did not step the count by one");

	// an edge leaves integral and previous error alone
	a_edge_keeps_loop: assert property (@(posedge clk) disable iff (!arst_n)
		advance && action_s1 == ACT_EDGE |=> $stable(integ_q) && $stable(prev_err_q))
		else $error("encoder edge changed the control state");

	// a tick that leaves the input register shows a result next cycle
	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && action_s1 == ACT_TICK |=> out_valid_q && position_q == $past(pos_ext))
		else $error("tick did not load the result register");

	// input stalls only behind a full, stalled result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && action_s1 == ACT_TICK && out_valid_q && out_stall)
		else $error("input stalled without cause");

	// a stalled result is not overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> $stable(drive_level_q) && $stable(drive_reverse_q))
		else $error("stalled result overwritten");
`endif

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps

module tb;
	import epc_pkg::*;

	localparam int     SETTLE_CYCLES  = 6;
	localparam int     WATCHDOG_LIMIT = 2000;
	localparam int     MAX_PRINTED    = 20;
	localparam longint ERR_HI   = (longint'(1) <<< (ERR_W - 1)) - 1;
	localparam longint ERR_LO   = -ERR_HI - 1;
	localparam longint INTEG_HI = (longint'(1) <<< (INTEGRAL_WIDTH_DEF - 1)) - 1;
	localparam longint INTEG_LO = -INTEG_HI - 1;
	localparam longint TERM_CLAMP = longint'(1) <<< TERM_LIMIT_EXP;
	localparam logic signed [POS_W-1:0] POS_HI = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic signed [POS_W-1:0] POS_LO = {1'b1, {(POS_W-1){1'b0}}};
	localparam logic signed [GAIN_W-1:0] GAIN_HI = {1'b0, {(GAIN_W-1){1'b1}}};
	localparam logic signed [GAIN_W-1:0] GAIN_LO = {1'b1, {(GAIN_W-1){1'b0}}};

	typedef struct packed {
		logic [LEVEL_W-1:0]      level;
		logic                    reverse;
		logic signed [POS_W-1:0] pos;
	} drive_cmd_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = CFG_PROP_GAIN;
	logic [GAIN_W-1:0]       cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic                    action = ACT_EDGE;
	logic                    channel_b_level = 1'b0;
	logic signed [POS_W-1:0] target_position = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [LEVEL_W-1:0]      drive_level;
	logic                    drive_reverse;
	logic signed [POS_W-1:0] position;

	// loop model state and gain copies
	logic signed [POS_W-1:0]  pos_count = '0;
	longint                   prev_err = 0;
	longint                   integ_acc = 0;
	logic signed [GAIN_W-1:0] kp = PROP_GAIN_RST;
	logic signed [GAIN_W-1:0] ki = INTEG_GAIN_RST;
	logic signed [GAIN_W-1:0] kd = DERIV_GAIN_RST;

	drive_cmd_t drive_cmd_q[$];
	drive_cmd_t oldest_cmd;
	int         fail_count = 0;
	int         idle_cycles = 0;
	int         send_idle_pct = 28;
	int         recv_idle_pct = 51;

	encoder_pid_position_control_top i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.action          (action),
		.channel_b_level (channel_b_level),
		.target_position (target_position),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.drive_level     (drive_level),
		.drive_reverse   (drive_reverse),
		.position        (position)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// random back-pressure on the result side
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// product term clamp applied before summing
	function automatic longint clamp_term(input longint prod);
		if (prod > TERM_CLAMP)
			return TERM_CLAMP;
		if (prod < -TERM_CLAMP)
			return -TERM_CLAMP;
		return prod;
	endfunction

	// one control tick: update error history and integral, form drive command
	function automatic drive_cmd_t predict_drive(input logic signed [POS_W-1:0] goal);
		longint     err;
		longint     slope;
		longint     ctl_sum;
		longint     mag;
		drive_cmd_t cmd;
		err = longint'(pos_count) - longint'(goal);
		if (err > ERR_HI)
			err = ERR_HI;
		else if (err < ERR_LO)
			err = ERR_LO;
		integ_acc = integ_acc + err;
		if (integ_acc > INTEG_HI)
			integ_acc = INTEG_HI;
		else if (integ_acc < INTEG_LO)
			integ_acc = INTEG_LO;
		slope = err - prev_err;
		prev_err = err;
		ctl_sum = clamp_term(longint'(kp) * err) + clamp_term(longint'(kd) * slope)
			+ clamp_term(longint'(ki) * integ_acc);
		mag = (ctl_sum < 0) ? -ctl_sum : ctl_sum;
		mag = mag >>> GAIN_FRACTION_BITS_DEF;
		if (mag > longint'(DRIVE_MAX))
			mag = longint'(DRIVE_MAX);
		cmd.level = mag[LEVEL_W-1:0];
		cmd.reverse = (ctl_sum < 0);
		cmd.pos = pos_count;
		return cmd;
	endfunction

	task automatic report_mismatch(input string msg);
		if (fail_count < MAX_PRINTED)
			$display("%0t: mismatch: %s", $time, msg);
		fail_count++;
	endtask

	// send one item, then update the model once it is taken
	task automatic send_item(input logic act, input logic b_level,
		input logic signed [POS_W-1:0] goal);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		channel_b_level <= b_level;
		target_position <= goal;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (act == ACT_TICK)
			drive_cmd_q.push_back(predict_drive(goal));
		else
			pos_count = b_level ? pos_count + 1 : pos_count - 1;
	endtask

	// hold off the sender until every drive command has come back
	task automatic await_results();
		in_valid <= 1'b0;
		while (drive_cmd_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write all three gains while the block is idle
	task automatic set_gains(input logic signed [GAIN_W-1:0] kp_val,
		input logic signed [GAIN_W-1:0] ki_val, input logic signed [GAIN_W-1:0] kd_val);
		await_results();
		cfg_we <= 1'b1;
		cfg_index <= CFG_PROP_GAIN;
		cfg_data <= kp_val;
		@(posedge clk);
		cfg_index <= CFG_INTEG_GAIN;
		cfg_data <= ki_val;
		@(posedge clk);
		cfg_index <= CFG_DERIV_GAIN;
		cfg_data <= kd_val;
		@(posedge clk);
		cfg_we <= 1'b0;
		kp = kp_val;
		ki = ki_val;
		kd = kd_val;
	endtask

	function automatic logic signed [GAIN_W-1:0] gain_near(input int span);
		return GAIN_W'(int'($urandom_range(2 * span)) - span);
	endfunction

	// bursts of encoder edges, mostly one way, each followed by a control tick
	task automatic run_motion(input int item_count, input bit wild);
		int                      sent;
		logic                    dir;
		logic signed [POS_W-1:0] goal;
		sent = 0;
		while (sent < item_count) begin
			dir = 1'($urandom_range(1));
			repeat ($urandom_range(12)) begin
				send_item(ACT_EDGE, ($urandom_range(9) == 0) ? !dir : dir, $urandom);
				sent++;
			end
			case ($urandom_range(9))
				0: begin
					goal = wild ? $urandom : pos_count;
				end
				1: begin
					goal = !wild ? pos_count : ($urandom_range(1) ? POS_HI : POS_LO);
				end
				default: begin
					goal = pos_count + int'($urandom_range(800)) - 400;
				end
			endcase
			send_item(ACT_TICK, 1'($urandom_range(1)), goal);
			sent++;
		end
	endtask

	// reset gains: unity proportional only
	task automatic test_reset_gains();
		send_item(ACT_TICK, 1'b0, 0);
		send_item(ACT_TICK, 1'b1, 5);
		send_item(ACT_TICK, 1'b0, -300);
		send_item(ACT_TICK, 1'b1, 255);
	endtask

	// edges count both ways, target ignored on edges, channel b ignored on ticks
	task automatic test_encoder_edges();
		repeat (3) send_item(ACT_EDGE, 1'b1, $urandom);
		repeat (5) send_item(ACT_EDGE, 1'b0, $urandom);
		send_item(ACT_TICK, 1'b1, 0);
	endtask

	// error clamps at both signed limits, integral nets out near zero
	task automatic test_error_saturation();
		send_item(ACT_TICK, 1'b0, POS_HI);
		repeat (3) send_item(ACT_EDGE, 1'b1, POS_LO);
		send_item(ACT_TICK, 1'b1, POS_LO);
		send_item(ACT_TICK, 1'b0, pos_count);
	endtask

	// control value below one drive step, both signs
	task automatic test_small_negative();
		set_gains(1, 0, 0);
		send_item(ACT_TICK, 1'b0, pos_count + 5);
		send_item(ACT_TICK, 1'b1, pos_count - 3);
	endtask

	// gain register extremes
	task automatic test_gain_extremes();
		set_gains(GAIN_HI, GAIN_LO, GAIN_LO);
		send_item(ACT_TICK, 1'b0, pos_count - 1);
		send_item(ACT_TICK, 1'b1, pos_count + 1);
		set_gains(GAIN_LO, GAIN_HI, GAIN_HI);
		send_item(ACT_TICK, 1'b1, pos_count + 2);
		send_item(ACT_TICK, 1'b0, pos_count - 7);
	endtask

	// targets near the count keep the integral small and the drive varied
	task automatic test_motion_tracking();
		set_gains(gain_near(1024), gain_near(8), gain_near(1024));
		run_motion(220, 1'b0);
		await_results();
		run_motion(220, 1'b0);
	endtask

	// far and extreme targets, no integral action
	task automatic test_wild_targets();
		send_idle_pct = 51;
		recv_idle_pct <= 28;
		set_gains(GAIN_W'($urandom), 0, GAIN_W'($urandom));
		run_motion(430, 1'b1);
	endtask

	// full-range gains, no idling on either side
	task automatic test_full_range_gains();
		send_idle_pct = 0;
		recv_idle_pct <= 0;
		repeat (3) begin
			set_gains(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom));
			run_motion(110, 1'b1);
		end
	endtask

	// push the integral hard both ways, with and without the term clamp
	task automatic test_integral_saturation();
		set_gains(256, 1, -1);
		repeat (20) send_item(ACT_TICK, 1'($urandom_range(1)), POS_LO);
		set_gains(gain_near(512), GAIN_HI, GAIN_HI);
		repeat (20) send_item(ACT_TICK, 1'($urandom_range(1)), POS_LO);
		set_gains(256, GAIN_LO, 3);
		repeat (20) send_item(ACT_TICK, 1'($urandom_range(1)), POS_HI);
		repeat (10) send_item(ACT_TICK, 1'($urandom_range(1)), pos_count + 100);
	endtask

	// compare each drive command with the oldest one predicted
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (drive_cmd_q.size() == 0) begin
				report_mismatch($sformatf("drive command at position %0d with none pending",
					position));
			end else begin
				oldest_cmd = drive_cmd_q.pop_front();
				if (drive_level !== oldest_cmd.level)
					report_mismatch($sformatf("drive_level %0d, expected %0d",
						drive_level, oldest_cmd.level));
				if (drive_reverse !== oldest_cmd.reverse)
					report_mismatch($sformatf("drive_reverse %0b, expected %0b",
						drive_reverse, oldest_cmd.reverse));
				if (position !== oldest_cmd.pos)
					report_mismatch($sformatf("position %0d, expected %0d",
						position, oldest_cmd.pos));
			end
		end
	end

	// watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// test sequence
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_gains();
		test_encoder_edges();
		test_error_saturation();
		test_small_negative();
		test_gain_extremes();
		test_motion_tracking();
		test_wild_targets();
		test_full_range_gains();
		test_integral_saturation();
		await_results();
		if (fail_count == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule

FILE: filelist.f
design/epc_pkg.sv
design/epc_calc.sv
design/encoder_pid_position_control_top.sv
test/tb.sv
